### rtl/thnl_pkg.sv
// ----------------------------------------------------------------------------
// thnl_pkg
// Shared types, constants and helpers for the timestamp history lookup block.
// ----------------------------------------------------------------------------
`default_nettype none

package thnl_pkg;

    // ring geometry
    localparam int HISTORY_DEPTH = 64;
    localparam int IDX_W         = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
    localparam int STAMP_W       = 64;
    localparam int PAYLOAD_W     = 64;

    // command codes
    typedef enum logic [1:0] {
        KIND_RECORD  = 2'd0,
        KIND_NEAREST = 2'd1,
        KIND_LATEST  = 2'd2,
        KIND_SPAN    = 2'd3
    } kind_t;

    // result status codes
    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_NONE_FOUND = 2'd1,
        STAT_EMPTY      = 2'd2,
        STAT_NOT_AFTER  = 2'd3
    } status_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_PICK,
        ST_SPAN
    } state_t;

    // input word
    typedef struct packed {
        kind_t                  kind;
        logic [STAMP_W-1:0]     stamp;
        logic [PAYLOAD_W-1:0]   sample_payload;
    } in_word_t;

    // result word
    typedef struct packed {
        status_t                status;
        logic [STAMP_W-1:0]     found_time;
        logic [PAYLOAD_W-1:0]   found_payload;
        logic [STAMP_W-1:0]     newest_time;
    } out_word_t;

    // one ring entry as stored in memory
    typedef struct packed {
        logic [STAMP_W-1:0]     stamp;
        logic [PAYLOAD_W-1:0]   payload;
    } entry_t;

    // memory access from the controller
    typedef struct packed {
        logic                   we;
        logic [IDX_W-1:0]       waddr;
        entry_t                 wdata;
        logic                   re;
        logic [IDX_W-1:0]       raddr;
    } mem_req_t;

    // slot one step back in the ring
    function automatic logic [IDX_W-1:0] prev_slot(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        if (idx == '0)
            res = IDX_W'(HISTORY_DEPTH - 1);
        else
            res = idx - IDX_W'(1);
        return res;
    endfunction

    // slot one step forward in the ring
    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        if (idx == IDX_W'(HISTORY_DEPTH - 1))
            res = '0;
        else
            res = idx + IDX_W'(1);
        return res;
    endfunction

endpackage

`default_nettype wire

### rtl/thnl_ram.sv
// ----------------------------------------------------------------------------
// thnl_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module thnl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        if (re)
            rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/thnl_ctrl.sv
// ----------------------------------------------------------------------------
// thnl_ctrl
// Ring pointers, command decode and the backward walk for nearest queries.
// ----------------------------------------------------------------------------
`default_nettype none

module thnl_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire thnl_pkg::in_word_t   cmd,
    output logic                      busy,
    output logic                      valid,
    output thnl_pkg::out_word_t       result,
    output thnl_pkg::mem_req_t        mem_req,
    input  wire thnl_pkg::entry_t     mem_rdata
);

    thnl_pkg::state_t                        state_reg, state_next;
    logic [thnl_pkg::IDX_W-1:0]              wr_slot_reg, wr_slot_next;
    logic [thnl_pkg::CNT_W-1:0]              fill_reg, fill_next;
    thnl_pkg::entry_t                        newest_reg, newest_next;
    thnl_pkg::entry_t                        after_reg, after_next;
    thnl_pkg::entry_t                        cand_reg, cand_next;
    logic [thnl_pkg::STAMP_W-1:0]            target_reg, target_next;
    logic [thnl_pkg::STAMP_W-1:0]            dl_reg, dl_next;
    logic [thnl_pkg::STAMP_W-1:0]            dh_reg, dh_next;
    logic [thnl_pkg::IDX_W-1:0]              rd_addr_reg, rd_addr_next;
    logic [thnl_pkg::CNT_W-1:0]              left_reg, left_next;
    logic                                    valid_reg, valid_next;
    thnl_pkg::out_word_t                     result_reg, result_next;

    logic                                    accept;
    logic                                    empty;
    logic [thnl_pkg::IDX_W-1:0]              newest_slot;

    assign accept      = start && (state_reg == thnl_pkg::ST_IDLE);
    assign empty       = (fill_reg == '0);
    assign newest_slot = thnl_pkg::prev_slot(wr_slot_reg);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= thnl_pkg::ST_IDLE;
            wr_slot_reg <= '0;
            fill_reg    <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            wr_slot_reg <= wr_slot_next;
            fill_reg    <= fill_next;
            valid_reg   <= valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        newest_reg  <= newest_next;
        after_reg   <= after_next;
        cand_reg    <= cand_next;
        target_reg  <= target_next;
        dl_reg      <= dl_next;
        dh_reg      <= dh_next;
        rd_addr_reg <= rd_addr_next;
        left_reg    <= left_next;
        result_reg  <= result_next;
    end

    // next state, memory access and result
    always_comb
    begin
        state_next   = state_reg;
        wr_slot_next = wr_slot_reg;
        fill_next    = fill_reg;
        newest_next  = newest_reg;
        after_next   = after_reg;
        cand_next    = cand_reg;
        target_next  = target_reg;
        dl_next      = dl_reg;
        dh_next      = dh_reg;
        rd_addr_next = rd_addr_reg;
        left_next    = left_reg;
        valid_next   = 1'b0;
        result_next  = result_reg;

        mem_req       = '0;
        mem_req.waddr = wr_slot_reg;
        mem_req.wdata = '{stamp: cmd.stamp, payload: cmd.sample_payload};

        unique case (state_reg)
            thnl_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    target_next = cmd.stamp;
                    if (cmd.kind == thnl_pkg::KIND_RECORD)
                    begin
                        // drop a repeat of the newest time
                        if (empty || (newest_reg.stamp != cmd.stamp))
                        begin
                            mem_req.we   = 1'b1;
                            newest_next  = mem_req.wdata;
                            wr_slot_next = thnl_pkg::next_slot(wr_slot_reg);
                            if (fill_reg != thnl_pkg::CNT_W'(thnl_pkg::HISTORY_DEPTH))
                                fill_next = fill_reg + thnl_pkg::CNT_W'(1);
                        end
                    end
                    else if (empty)
                    begin
                        valid_next  = 1'b1;
                        result_next = '{status: thnl_pkg::STAT_EMPTY, found_time: '0,
                                        found_payload: '0, newest_time: '0};
                    end
                    else
                    begin
                        unique case (cmd.kind)
                            thnl_pkg::KIND_LATEST:
                            begin
                                valid_next  = 1'b1;
                                result_next = '{status: thnl_pkg::STAT_OK,
                                                found_time: newest_reg.stamp,
                                                found_payload: newest_reg.payload,
                                                newest_time: newest_reg.stamp};
                            end
                            thnl_pkg::KIND_SPAN:
                            begin
                                // oldest is slot zero until the ring wraps
                                mem_req.re = 1'b1;
                                if (fill_reg == thnl_pkg::CNT_W'(thnl_pkg::HISTORY_DEPTH))
                                    mem_req.raddr = wr_slot_reg;
                                else
                                    mem_req.raddr = '0;
                                state_next = thnl_pkg::ST_SPAN;
                            end
                            thnl_pkg::KIND_NEAREST:
                            begin
                                if (!(newest_reg.stamp > cmd.stamp))
                                begin
                                    valid_next  = 1'b1;
                                    result_next = '{status: thnl_pkg::STAT_NOT_AFTER,
                                                    found_time: '0, found_payload: '0,
                                                    newest_time: newest_reg.stamp};
                                end
                                else if (fill_reg == thnl_pkg::CNT_W'(1))
                                begin
                                    valid_next  = 1'b1;
                                    result_next = '{status: thnl_pkg::STAT_NONE_FOUND,
                                                    found_time: '0, found_payload: '0,
                                                    newest_time: newest_reg.stamp};
                                end
                                else
                                begin
                                    // newest is past the target, walk from the one below
                                    after_next    = newest_reg;
                                    left_next     = fill_reg - thnl_pkg::CNT_W'(1);
                                    rd_addr_next  = thnl_pkg::prev_slot(newest_slot);
                                    mem_req.re    = 1'b1;
                                    mem_req.raddr = rd_addr_next;
                                    state_next    = thnl_pkg::ST_WALK;
                                end
                            end
                            default:
                            begin
                                valid_next = 1'b0;
                            end
                        endcase
                    end
                end
            end

            thnl_pkg::ST_WALK:
            begin
                if (mem_rdata.stamp <= target_reg)
                begin
                    // register both distances, choose next cycle
                    cand_next  = mem_rdata;
                    dl_next    = target_reg - mem_rdata.stamp;
                    dh_next    = after_reg.stamp - target_reg;
                    state_next = thnl_pkg::ST_PICK;
                end
                else if (left_reg == thnl_pkg::CNT_W'(1))
                begin
                    valid_next  = 1'b1;
                    result_next = '{status: thnl_pkg::STAT_NONE_FOUND,
                                    found_time: '0, found_payload: '0,
                                    newest_time: newest_reg.stamp};
                    state_next  = thnl_pkg::ST_IDLE;
                end
                else
                begin
                    after_next    = mem_rdata;
                    left_next     = left_reg - thnl_pkg::CNT_W'(1);
                    rd_addr_next  = thnl_pkg::prev_slot(rd_addr_reg);
                    mem_req.re    = 1'b1;
                    mem_req.raddr = rd_addr_next;
                end
            end

            thnl_pkg::ST_PICK:
            begin
                // tie goes to the later entry
                valid_next = 1'b1;
                if (dl_reg < dh_reg)
                    result_next = '{status: thnl_pkg::STAT_OK,
                                    found_time: cand_reg.stamp,
                                    found_payload: cand_reg.payload,
                                    newest_time: newest_reg.stamp};
                else
                    result_next = '{status: thnl_pkg::STAT_OK,
                                    found_time: after_reg.stamp,
                                    found_payload: after_reg.payload,
                                    newest_time: newest_reg.stamp};
                state_next = thnl_pkg::ST_IDLE;
            end

            thnl_pkg::ST_SPAN:
            begin
                valid_next  = 1'b1;
                result_next = '{status: thnl_pkg::STAT_OK,
                                found_time: mem_rdata.stamp, found_payload: '0,
                                newest_time: newest_reg.stamp};
                state_next  = thnl_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = thnl_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != thnl_pkg::ST_IDLE);
    assign valid  = valid_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

### rtl/timestamp_history_nearest_lookup.sv
// Record: no result, busy stays low, a new word may follow in the next cycle.
// Latest query, empty history and target not before newest: result strobe in
// the cycle after start. Span query: the oldest entry is read, then registered.
// Nearest query: entries are read back newest first from the single memory port.
// Results are presented for one cycle on valid; the receiver cannot stall.
// Reset clears the ring pointers and fill count; ring contents stay as they are.
// ----------------------------------------------------------------------------
// timestamp_history_nearest_lookup
// Ring of timestamped samples with nearest, latest and span lookups.
// ----------------------------------------------------------------------------
`default_nettype none

module timestamp_history_nearest_lookup (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire thnl_pkg::in_word_t   cmd,
    output logic                      busy,
    output logic                      valid,
    output thnl_pkg::out_word_t       result
);

    localparam int ENTRY_W = $bits(thnl_pkg::entry_t);

    thnl_pkg::mem_req_t   mem_req;
    thnl_pkg::entry_t     mem_rdata;
    logic [ENTRY_W-1:0]   ram_rdata;

    // command decode and walk
    thnl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .busy      (busy),
        .valid     (valid),
        .result    (result),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    // sample ring storage
    thnl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (thnl_pkg::HISTORY_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (ram_rdata)
    );

    assign mem_rdata = thnl_pkg::entry_t'(ram_rdata);

endmodule

`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the timestamp history lookup block. Command words
// are queued up front (a short directed set, then three random phases with
// different sender idle rates) and driven by a clocked driver. A local copy
// of the sample ring predicts each answer as its word is taken, and a
// clocked monitor checks every answer strobe against the oldest prediction.
// ----------------------------------------------------------------------------

module tb_top;

    localparam int PHASE_WORDS = 410;
    localparam int QUIET_LIMIT = 4000;

    // one queued command word with its sender behavior
    typedef struct {
        thnl_pkg::in_word_t word;
        int unsigned        idle_pct;
        bit                 drain_first;
    } queued_word_t;

    logic                 clk   = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    thnl_pkg::in_word_t   cmd   = '0;
    logic                 busy;
    logic                 valid;
    thnl_pkg::out_word_t  result;

    // bench copy of the sample ring
    logic [thnl_pkg::STAMP_W-1:0]   ring_time    [thnl_pkg::HISTORY_DEPTH];
    logic [thnl_pkg::PAYLOAD_W-1:0] ring_payload [thnl_pkg::HISTORY_DEPTH];
    logic [thnl_pkg::IDX_W-1:0]     ring_head    = '0;
    logic [thnl_pkg::CNT_W-1:0]     ring_fill    = '0;

    queued_word_t         queued_words[$];
    thnl_pkg::out_word_t  pending_answers[$];

    int unsigned sender_idle     = 28;
    int unsigned answers_due     = 0;
    int unsigned answers_seen    = 0;
    int unsigned words_taken     = 0;
    int unsigned samples_stored  = 0;
    int unsigned samples_dropped = 0;
    int unsigned ring_wraps      = 0;
    int unsigned status_seen [4] = '{0, 0, 0, 0};
    int unsigned mismatches      = 0;
    int unsigned quiet_cycles    = 0;

    timestamp_history_nearest_lookup dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .valid  (valid),
        .result (result)
    );

    // clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // slot k steps back from the newest sample
    function automatic int unsigned slot_back(input int unsigned k);
        return (32'(ring_head) + thnl_pkg::HISTORY_DEPTH - 1
                - (k % thnl_pkg::HISTORY_DEPTH)) % thnl_pkg::HISTORY_DEPTH;
    endfunction

    // apply one word to the ring copy and work out the answer it causes
    function automatic void lookup_history(input thnl_pkg::in_word_t w,
                                           output bit has_answer,
                                           output thnl_pkg::out_word_t answer);
        int unsigned newest;
        int unsigned oldest;
        int unsigned s;
        int unsigned succ;
        int unsigned pick;
        logic [thnl_pkg::STAMP_W-1:0] newest_t;
        logic [thnl_pkg::STAMP_W-1:0] dl;
        logic [thnl_pkg::STAMP_W-1:0] dh;
        bit hit;
        answer     = '0;
        has_answer = 1'b0;
        hit        = 1'b0;
        // record: drop a repeat of the newest time, else write and advance
        if (w.kind == thnl_pkg::KIND_RECORD)
        begin
            if (ring_fill != 0 && ring_time[slot_back(0)] == w.stamp)
            begin
                samples_dropped++;
            end
            else
            begin
                ring_time[ring_head]    = w.stamp;
                ring_payload[ring_head] = w.sample_payload;
                ring_head = thnl_pkg::IDX_W'((32'(ring_head) + 1)
                                             % thnl_pkg::HISTORY_DEPTH);
                if (ring_head == 0)
                    ring_wraps++;
                if (ring_fill < thnl_pkg::HISTORY_DEPTH)
                    ring_fill++;
                samples_stored++;
            end
            return;
        end
        has_answer = 1'b1;
        // empty history answers every query the same way
        if (ring_fill == 0)
        begin
            answer.status = thnl_pkg::STAT_EMPTY;
            status_seen[int'(thnl_pkg::STAT_EMPTY)]++;
            return;
        end
        newest             = slot_back(0);
        newest_t           = ring_time[newest];
        answer.newest_time = newest_t;
        answer.status      = thnl_pkg::STAT_OK;
        if (w.kind == thnl_pkg::KIND_LATEST)
        begin
            answer.found_time    = newest_t;
            answer.found_payload = ring_payload[newest];
        end
        else if (w.kind == thnl_pkg::KIND_SPAN)
        begin
            oldest = (ring_fill < thnl_pkg::HISTORY_DEPTH) ? 0 : 32'(ring_head);
            answer.found_time = ring_time[oldest];
        end
        else if (newest_t <= w.stamp)
        begin
            answer.status = thnl_pkg::STAT_NOT_AFTER;
        end
        else
        begin
            // walk back to the first sample at or before the target
            answer.status = thnl_pkg::STAT_NONE_FOUND;
            succ = newest;
            for (int k = 0; k < int'(ring_fill) && !hit; k++)
            begin
                s = slot_back(k);
                if (ring_time[s] <= w.stamp)
                begin
                    dl   = w.stamp - ring_time[s];
                    dh   = ring_time[succ] - w.stamp;
                    pick = (dl < dh) ? s : succ;
                    answer.status        = thnl_pkg::STAT_OK;
                    answer.found_time    = ring_time[pick];
                    answer.found_payload = ring_payload[pick];
                    hit = 1'b1;
                end
                else
                begin
                    succ = s;
                end
            end
        end
        status_seen[int'(answer.status)]++;
    endfunction

    // driver: predict each taken word, then present the next queued one
    always @(posedge clk or negedge rst_n)
    begin
        bit                  has_answer;
        thnl_pkg::out_word_t answer;
        bit                  go;
        if (!rst_n)
        begin
            start <= 1'b0;
            cmd   <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                lookup_history(cmd, has_answer, answer);
                words_taken++;
                if (has_answer)
                begin
                    pending_answers = {pending_answers, answer};
                    answers_due++;
                end
            end
            if (!start || !busy)
            begin
                go = queued_words.size() != 0;
                if (go && queued_words[0].drain_first && answers_due != answers_seen)
                    go = 1'b0;
                if (go && $urandom_range(99) < queued_words[0].idle_pct)
                    go = 1'b0;
                if (go)
                begin
                    cmd   <= queued_words[0].word;
                    start <= 1'b1;
                    void'(queued_words.pop_front());
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // compare one answer field
    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // monitor: every strobe is checked against the oldest prediction
    always @(posedge clk)
    begin
        thnl_pkg::out_word_t want;
        if (rst_n && valid)
        begin
            if (pending_answers.size() == 0)
            begin
                $display("%0t: unexpected answer word, expected none, got %h",
                         $time, result);
                mismatches++;
            end
            else
            begin
                want = pending_answers.pop_front();
                check_field("status", 64'(want.status), 64'(result.status));
                check_field("found_time", want.found_time, result.found_time);
                check_field("found_payload", want.found_payload, result.found_payload);
                check_field("newest_time", want.newest_time, result.newest_time);
                answers_seen <= answers_seen + 1;
            end
        end
    end

    // watchdog on cycles with no word taken and no answer
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || valid)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no traffic for %0d cycles, %0d answers outstanding",
                     $time, quiet_cycles, pending_answers.size());
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic void queue_word(input thnl_pkg::kind_t kind,
                                       input logic [63:0] stamp,
                                       input logic [63:0] payload, input bit drain);
        queued_word_t q;
        q.word.kind           = kind;
        q.word.stamp          = stamp;
        q.word.sample_payload = payload;
        q.idle_pct            = sender_idle;
        q.drain_first         = drain;
        queued_words = {queued_words, q};
    endfunction

    // stimulus, reset and end of run
    initial
    begin
        logic [63:0] clock_now;
        logic [63:0] last_stamp;
        logic [63:0] last_step;
        logic [63:0] stamp;
        logic [63:0] recent_stamps[$];
        int unsigned pick;
        int unsigned mode;
        bit          drain;

        // directed: empty history, repeats, ties, exact hits, extremes, disorder
        queue_word(thnl_pkg::KIND_NEAREST, 64'd0, 64'd0, 1'b0);
        queue_word(thnl_pkg::KIND_LATEST, 64'd0, '1, 1'b0);
        queue_word(thnl_pkg::KIND_SPAN, '1, 64'd0, 1'b0);
        queue_word(thnl_pkg::KIND_RECORD, 64'd100, '1, 1'b0);
        queue_word(thnl_pkg::KIND_RECORD, 64'd100, 64'h1234, 1'b0);
        queue_word(thnl_pkg::KIND_LATEST, 64'd0, 64'd0, 1'b0);
        queue_word(thnl_pkg::KIND_SPAN, 64'd0, 64'd0, 1'b0);
        queue_word(thnl_pkg::KIND_NEAREST, 64'd100, 64'd0, 1'b0);
        queue_word(thnl_pkg::KIND_NEAREST, 64'd99, 64'd0, 1'b0);
        queue_word(thnl_pkg::KIND_RECORD, 64'd200, 64'hA5A5_A5A5_A5A5_A5A5, 1'b0);
        queue_word(thnl_pkg::KIND_RECORD, 64'd300, 64'h5A5A_5A5A_5A5A_5A5A, 1'b0);
        queue_word(thnl_pkg::KIND_NEAREST, 64'd250, 64'd0, 1'b0);
        queue_word(thnl_pkg::KIND_NEAREST, 64'd240, 64'd0, 1'b0);
        queue_word(thnl_pkg::KIND_NEAREST, 64'd200, 64'd0, 1'b0);
        queue_word(thnl_pkg::KIND_NEAREST, 64'd299, 64'd0, 1'b0);
        queue_word(thnl_pkg::KIND_NEAREST, 64'd0, 64'd0, 1'b0);
        queue_word(thnl_pkg::KIND_NEAREST, '1, 64'd0, 1'b0);
        queue_word(thnl_pkg::KIND_SPAN, 64'd0, 64'd0, 1'b0);
        queue_word(thnl_pkg::KIND_RECORD, 64'd0, 64'h0F0F_0F0F_0F0F_0F0F, 1'b0);
        queue_word(thnl_pkg::KIND_NEAREST, 64'd0, 64'd0, 1'b0);
        queue_word(thnl_pkg::KIND_RECORD, '1, 64'd0, 1'b0);
        queue_word(thnl_pkg::KIND_NEAREST, 64'hFFFF_FFFF_FFFF_FFFE, 64'd0, 1'b0);
        queue_word(thnl_pkg::KIND_NEAREST, 64'd150, 64'd0, 1'b0);
        queue_word(thnl_pkg::KIND_LATEST, 64'd0, 64'd0, 1'b0);
        queue_word(thnl_pkg::KIND_SPAN, 64'd0, 64'd0, 1'b1);

        // random phases: sender idles 28%, then 52%, then never
        last_stamp = '1;
        last_step  = 64'd2;
        for (int phase = 0; phase < 3; phase++)
        begin
            sender_idle = (phase == 0) ? 28 : (phase == 1) ? 52 : 0;
            clock_now   = rand64() >> 1;
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                pick  = $urandom_range(99);
                drain = (n == 0) || ($urandom_range(149) == 0);
                if (pick < 45)
                begin
                    // mostly rising times, some repeats and some out of order
                    mode = $urandom_range(99);
                    if (mode < 8)
                    begin
                        stamp = rand64();
                    end
                    else if (mode < 15)
                    begin
                        stamp = last_stamp;
                    end
                    else
                    begin
                        last_step = $urandom_range(1) ? 64'(2 * $urandom_range(1, 250))
                                                      : 64'($urandom_range(1, 500));
                        clock_now += last_step;
                        stamp = clock_now;
                        recent_stamps = {recent_stamps, stamp};
                        if (recent_stamps.size() > thnl_pkg::HISTORY_DEPTH)
                            void'(recent_stamps.pop_front());
                    end
                    last_stamp = stamp;
                    queue_word(thnl_pkg::KIND_RECORD, stamp, rand64(), drain);
                end
                else if (pick < 80)
                begin
                    // nearest targets spread over the stored window and beyond
                    mode = $urandom_range(99);
                    if (mode < 35)
                        stamp = clock_now - 64'($urandom_range(0, 20000));
                    else if (mode < 50)
                        stamp = last_stamp - last_step / 2;
                    else if (mode < 70 && recent_stamps.size() != 0)
                        stamp = recent_stamps[$urandom_range(recent_stamps.size() - 1)]
                                - 64'($urandom_range(1)) + 64'($urandom_range(1));
                    else if (mode < 80)
                        stamp = clock_now - 64'($urandom_range(40000, 200000));
                    else if (mode < 88)
                        stamp = last_stamp + 64'($urandom_range(0, 3));
                    else if (mode < 95)
                        stamp = rand64();
                    else
                        stamp = $urandom_range(1) ? '1 : '0;
                    queue_word(thnl_pkg::KIND_NEAREST, stamp, rand64(), drain);
                end
                else if (pick < 90)
                begin
                    queue_word(thnl_pkg::KIND_LATEST, rand64(), rand64(), drain);
                end
                else
                begin
                    queue_word(thnl_pkg::KIND_SPAN, rand64(), rand64(), drain);
                end
            end
        end

        // reset
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // wait for every word to be taken and every answer to arrive
        while (queued_words.size() != 0 || start || answers_due != answers_seen)
            @(posedge clk);
        repeat (thnl_pkg::HISTORY_DEPTH + 4) @(posedge clk);

        if (pending_answers.size() != 0)
        begin
            $display("%0t: %0d answers never arrived, oldest expected %h",
                     $time, pending_answers.size(), pending_answers[0]);
            mismatches++;
        end

        $display("covered %0d words: %0d samples stored, %0d repeats dropped",
                 words_taken, samples_stored, samples_dropped);
        $display("ring wrapped %0d times; answers checked %0d; ok/none/empty/not-after %0d/%0d/%0d/%0d",
                 ring_wraps, answers_seen, status_seen[0], status_seen[1],
                 status_seen[2], status_seen[3]);
        if (mismatches == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/thnl_pkg.sv
rtl/thnl_ram.sv
rtl/thnl_ctrl.sv
rtl/timestamp_history_nearest_lookup.sv
sim/tb_top.sv
